@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros used by the checker file gild_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked out of reset only
`define CHK_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define CHK_PROP_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/gild_pkg.sv @@
// ----------------------------------------------------------------------------
// gild_pkg
// types and constants of the guest idle loop detector
// ----------------------------------------------------------------------------
package gild_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 32;

    localparam int ARG_W   = 32;
    localparam int MODE_W  = 3;
    localparam int LIMIT_W = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [LIMIT_W-1:0] SEMA_LIMIT_RST   = 16'd100;
    localparam logic [LIMIT_W-1:0] ROTATE_LIMIT_RST = 16'd500;
    localparam logic [LIMIT_W-1:0] BOUNCE_LIMIT_RST = 16'd1000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SEMA_LIMIT   = 2'd0,
        REG_ROTATE_LIMIT = 2'd1,
        REG_BOUNCE_LIMIT = 2'd2
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_WAIT_SEMA   = 3'd0,
        MODE_SIGNAL_SEMA = 3'd1,
        MODE_INTERRUPT   = 3'd2,
        MODE_CHANGE_THR  = 3'd3,
        MODE_ROTATE      = 3'd4,
        MODE_OTHER       = 3'd5
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ARG_W-1:0]  first_arg;
        logic [ARG_W-1:0]  second_arg;
    } t_in_word;

    typedef struct packed {
        logic idle;
        logic sema_idle;
        logic rotate_idle;
        logic bounce_idle;
    } t_out_word;

endpackage

@@ hdl/guest_idle_loop_detector.sv @@
// ----------------------------------------------------------------------------
// guest_idle_loop_detector
// the accepted word is registered in the input reg, which feeds the result reg
// throughput: one word per cycle while the output is not stalled
// input stalls only while a result is held by a stalled output
// reset: synchronous active low, limits return to 100/500/1000, ids to all
// ones, counters and flags to zero, both pipeline stages empty
// ----------------------------------------------------------------------------
module guest_idle_loop_detector #(
    parameter int COUNT_WIDTH = gild_pkg::COUNT_WIDTH_DEF,
    parameter int ID_WIDTH    = gild_pkg::ID_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  gild_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output gild_pkg::t_out_word                 o_out_word,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gild_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gild_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gild_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import gild_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [LIMIT_W-1:0] r_sema_limit, r_rotate_limit, r_bounce_limit;

    logic                   r_in_valid;
    t_in_word               r_in_word;
    logic                   r_out_valid;
    t_out_word              r_out_word;

    logic [ID_WIDTH-1:0]    r_last_sema, n_last_sema;
    logic [COUNT_WIDTH-1:0] r_sema_cnt, n_sema_cnt;
    logic                   r_sema_flag, n_sema_flag;
    logic [ID_WIDTH-1:0]    r_rot_thr, n_rot_thr;
    logic [COUNT_WIDTH-1:0] r_rot_cnt, n_rot_cnt;
    logic                   r_rot_flag, n_rot_flag;
    logic [ID_WIDTH-1:0]    r_pair_a, n_pair_a;
    logic [ID_WIDTH-1:0]    r_pair_b, n_pair_b;
    logic [COUNT_WIDTH-1:0] r_bnc_cnt, n_bnc_cnt;
    logic                   n_bnc_flag;

    logic                   advance, in_accept, cfg_write;
    logic [ID_WIDTH-1:0]    arg_a, arg_b;
    logic [COUNT_WIDTH-1:0] sema_inc, rot_inc, bnc_inc;
    logic                   has_a, has_b;
    t_reg_idx               cfg_idx;
    t_out_word              n_out_word;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = t_reg_idx'(paddr[REG_IDX_W+1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sema_limit   <= SEMA_LIMIT_RST;
            r_rotate_limit <= ROTATE_LIMIT_RST;
            r_bounce_limit <= BOUNCE_LIMIT_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_SEMA_LIMIT:   r_sema_limit   <= pwdata[LIMIT_W-1:0];
                REG_ROTATE_LIMIT: r_rotate_limit <= pwdata[LIMIT_W-1:0];
                REG_BOUNCE_LIMIT: r_bounce_limit <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SEMA_LIMIT:   prdata = APB_DATA_W'(r_sema_limit);
            REG_ROTATE_LIMIT: prdata = APB_DATA_W'(r_rotate_limit);
            REG_BOUNCE_LIMIT: prdata = APB_DATA_W'(r_bounce_limit);
            default:          prdata = '0;
        endcase
    end

    // pipeline handshake
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
        if (advance && r_in_valid) begin
            r_out_word <= n_out_word;
        end
    end

    // detector update
    assign arg_a    = r_in_word.first_arg[ID_WIDTH-1:0];
    assign arg_b    = r_in_word.second_arg[ID_WIDTH-1:0];
    assign sema_inc = (r_sema_cnt == '1) ? r_sema_cnt : r_sema_cnt + 1'b1;
    assign rot_inc  = (r_rot_cnt == '1) ? r_rot_cnt : r_rot_cnt + 1'b1;
    assign bnc_inc  = (r_bnc_cnt == '1) ? r_bnc_cnt : r_bnc_cnt + 1'b1;
    assign has_a    = (arg_a == r_pair_a) || (arg_b == r_pair_a);
    assign has_b    = (arg_a == r_pair_b) || (arg_b == r_pair_b);

    always_comb begin
        n_last_sema = r_last_sema;
        n_sema_cnt  = r_sema_cnt;
        n_sema_flag = r_sema_flag;
        n_rot_thr   = r_rot_thr;
        n_rot_cnt   = r_rot_cnt;
        n_rot_flag  = r_rot_flag;
        n_pair_a    = r_pair_a;
        n_pair_b    = r_pair_b;
        n_bnc_cnt   = r_bnc_cnt;
        case (r_in_word.mode)
            MODE_WAIT_SEMA, MODE_SIGNAL_SEMA: begin
                if (r_last_sema == arg_a) begin
                    n_sema_cnt = sema_inc;
                    if (CMP_W'(sema_inc) >= CMP_W'(r_sema_limit)) begin
                        n_sema_flag = 1'b1;
                    end
                end else begin
                    n_sema_cnt  = '0;
                    n_sema_flag = 1'b0;
                end
                n_last_sema = arg_a;
            end
            MODE_INTERRUPT: begin
                n_sema_cnt  = '0;
                n_sema_flag = 1'b0;
                n_last_sema = '1;
                n_rot_cnt   = '0;
                n_rot_flag  = 1'b0;
                n_bnc_cnt   = '0;
            end
            MODE_CHANGE_THR: begin
                n_sema_cnt  = '0;
                n_sema_flag = 1'b0;
                n_last_sema = '1;
                if (arg_a != r_rot_thr) begin
                    n_rot_cnt  = '0;
                    n_rot_flag = 1'b0;
                end
                if (arg_a != r_pair_a && arg_a != r_pair_b) begin
                    n_bnc_cnt = '0;
                end
            end
            MODE_ROTATE: begin
                if (arg_a == arg_b) begin
                    n_rot_cnt = rot_inc;
                    n_rot_thr = arg_a;
                    if (CMP_W'(rot_inc) > CMP_W'(r_rotate_limit)) begin
                        n_rot_flag = 1'b1;
                    end
                end else begin
                    n_rot_cnt  = '0;
                    n_rot_thr  = '1;
                    n_rot_flag = 1'b0;
                end
                n_bnc_cnt = (has_a && has_b) ? bnc_inc : '0;
                n_pair_a  = arg_a;
                n_pair_b  = arg_b;
            end
            default: ;
        endcase
        n_bnc_flag = CMP_W'(n_bnc_cnt) > CMP_W'(r_bounce_limit);
        n_out_word.sema_idle   = n_sema_flag;
        n_out_word.rotate_idle = n_rot_flag;
        n_out_word.bounce_idle = n_bnc_flag;
        n_out_word.idle        = n_sema_flag || n_rot_flag || n_bnc_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sema <= '1;
            r_sema_cnt  <= '0;
            r_sema_flag <= 1'b0;
            r_rot_thr   <= '1;
            r_rot_cnt   <= '0;
            r_rot_flag  <= 1'b0;
            r_pair_a    <= '1;
            r_pair_b    <= '1;
            r_bnc_cnt   <= '0;
        end else if (advance && r_in_valid) begin
            r_last_sema <= n_last_sema;
            r_sema_cnt  <= n_sema_cnt;
            r_sema_flag <= n_sema_flag;
            r_rot_thr   <= n_rot_thr;
            r_rot_cnt   <= n_rot_cnt;
            r_rot_flag  <= n_rot_flag;
            r_pair_a    <= n_pair_a;
            r_pair_b    <= n_pair_b;
            r_bnc_cnt   <= n_bnc_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ hdl/gild_checker.sv @@
// ----------------------------------------------------------------------------
// gild_checker
// port-level checks of the guest idle loop detector, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gild_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  gild_pkg::t_in_word                  i_in_word,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  gild_pkg::t_out_word                 o_out_word,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gild_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gild_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [gild_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                                pready
);
    import gild_pkg::*;

    // summary flag is the or of the detector flags
    `CHK_PROP(a_idle_or, i_clk, i_rst_n, o_out_valid |-> (o_out_word.idle == (o_out_word.sema_idle || o_out_word.rotate_idle || o_out_word.bounce_idle)), "idle is not the or of the flags")

    // input only backs up behind a held result
    `CHK_PROP(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled without output backpressure")

    // held result word keeps its value
    `CHK_PROP(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)), "stalled result word changed")

    // reset empties the pipeline
    `CHK_PROP_ALL(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid right after reset")

endmodule

bind guest_idle_loop_detector gild_checker u_gild_checker (.*);

@@ tb/guest_idle_loop_detector_checker.sv @@
// ----------------------------------------------------------------------------
// guest_idle_loop_detector_checker
// watches the event and flag channels and the register port, keeps its own
// copy of the three idle detectors and their limits, and compares every
// accepted flag word with the oldest predicted one; register reads are
// checked against the limits it has seen written
// ----------------------------------------------------------------------------
module guest_idle_loop_detector_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  gild_pkg::t_in_word              i_in_word,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  gild_pkg::t_out_word             i_out_word,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [gild_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [gild_pkg::APB_DATA_W-1:0] i_pwdata,
    input  logic [gild_pkg::APB_DATA_W-1:0] i_prdata,
    output int                              o_fail_count,
    output int                              o_due_count
);
    import gild_pkg::*;

    localparam int CNT_W = COUNT_WIDTH_DEF;
    localparam int ID_W  = ID_WIDTH_DEF;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [ID_W-1:0]  ID_NONE = '1;

    logic [LIMIT_W-1:0] sema_lim;
    logic [LIMIT_W-1:0] rot_lim;
    logic [LIMIT_W-1:0] bnc_lim;

    logic [ID_W-1:0]  sema_id;
    logic [ID_W-1:0]  rot_thr;
    logic [ID_W-1:0]  pair_a;
    logic [ID_W-1:0]  pair_b;
    logic [CNT_W-1:0] sema_cnt;
    logic [CNT_W-1:0] rot_cnt;
    logic [CNT_W-1:0] bnc_cnt;
    logic             sema_hit;
    logic             rot_hit;
    logic             bnc_hit;

    t_out_word flags_due[$];

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    task automatic advance_detectors(input t_in_word w, output t_out_word f);
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        logic            has_a;
        logic            has_b;
        a = w.first_arg[ID_W-1:0];
        b = w.second_arg[ID_W-1:0];

        // semaphore repeats
        case (w.mode)
            MODE_WAIT_SEMA, MODE_SIGNAL_SEMA: begin
                if (sema_id == a) begin
                    sema_cnt = bump(sema_cnt);
                    if (sema_cnt >= sema_lim) sema_hit = 1'b1;
                end else begin
                    sema_cnt = '0;
                    sema_hit = 1'b0;
                end
                sema_id = a;
            end
            MODE_INTERRUPT, MODE_CHANGE_THR: begin
                sema_cnt = '0;
                sema_id  = ID_NONE;
                sema_hit = 1'b0;
            end
            default: ;
        endcase

        // self rotation
        case (w.mode)
            MODE_ROTATE: begin
                if (a == b) begin
                    rot_cnt = bump(rot_cnt);
                    rot_thr = a;
                    if (rot_cnt > rot_lim) rot_hit = 1'b1;
                end else begin
                    rot_cnt = '0;
                    rot_thr = ID_NONE;
                    rot_hit = 1'b0;
                end
            end
            MODE_CHANGE_THR: begin
                if (a != rot_thr) begin
                    rot_cnt = '0;
                    rot_hit = 1'b0;
                end
            end
            MODE_INTERRUPT: begin
                rot_cnt = '0;
                rot_hit = 1'b0;
            end
            default: ;
        endcase

        // pair bounce
        case (w.mode)
            MODE_ROTATE: begin
                has_a   = (a == pair_a) || (b == pair_a);
                has_b   = (a == pair_b) || (b == pair_b);
                bnc_cnt = (has_a && has_b) ? bump(bnc_cnt) : '0;
                pair_a  = a;
                pair_b  = b;
            end
            MODE_CHANGE_THR: begin
                if (a != pair_a && a != pair_b) bnc_cnt = '0;
            end
            MODE_INTERRUPT: bnc_cnt = '0;
            default: ;
        endcase
        bnc_hit = bnc_cnt > bnc_lim;

        f.sema_idle   = sema_hit;
        f.rotate_idle = rot_hit;
        f.bounce_idle = bnc_hit;
        f.idle        = sema_hit | rot_hit | bnc_hit;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word          want;
        logic [LIMIT_W-1:0] reg_val;
        logic               mapped;
        if (!i_rst_n) begin
            sema_lim = SEMA_LIMIT_RST;
            rot_lim  = ROTATE_LIMIT_RST;
            bnc_lim  = BOUNCE_LIMIT_RST;
            sema_id  = ID_NONE;
            rot_thr  = ID_NONE;
            pair_a   = ID_NONE;
            pair_b   = ID_NONE;
            sema_cnt = '0;
            rot_cnt  = '0;
            bnc_cnt  = '0;
            sema_hit = 1'b0;
            rot_hit  = 1'b0;
            bnc_hit  = 1'b0;
            flags_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (flags_due.size() == 0) begin
                    $display("%0t: flag word with none due: got %b", $time, i_out_word);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = flags_due.pop_front();
                    if (i_out_word !== want) begin
                        $display("%0t: flags mismatch: expected %b%b%b%b actual %b%b%b%b",
                                 $time, want.idle, want.sema_idle, want.rotate_idle,
                                 want.bounce_idle, i_out_word.idle, i_out_word.sema_idle,
                                 i_out_word.rotate_idle, i_out_word.bounce_idle);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_detectors(i_in_word, want);
                flags_due.push_back(want);
            end
            if (i_psel && i_penable && i_pready) begin
                mapped = 1'b1;
                case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                    REG_SEMA_LIMIT:   reg_val = sema_lim;
                    REG_ROTATE_LIMIT: reg_val = rot_lim;
                    REG_BOUNCE_LIMIT: reg_val = bnc_lim;
                    default: begin
                        reg_val = '0;
                        mapped  = 1'b0;
                    end
                endcase
                if (i_pwrite) begin
                    case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                        REG_SEMA_LIMIT:   sema_lim = i_pwdata[LIMIT_W-1:0];
                        REG_ROTATE_LIMIT: rot_lim  = i_pwdata[LIMIT_W-1:0];
                        REG_BOUNCE_LIMIT: bnc_lim  = i_pwdata[LIMIT_W-1:0];
                        default: ;
                    endcase
                end else if (mapped && i_prdata[LIMIT_W-1:0] !== reg_val) begin
                    $display("%0t: register read at %h: expected %h actual %h",
                             $time, i_paddr, reg_val, i_prdata[LIMIT_W-1:0]);
                    o_fail_count = o_fail_count + 1;
                end
            end
        end
        o_due_count = flags_due.size();
    end

endmodule

@@ tb/guest_idle_loop_detector_tb.sv @@
// ----------------------------------------------------------------------------
// guest_idle_loop_detector_tb
// drives kernel events into the idle loop detector: a short directed run,
// then bursts of semaphore repeats, self rotations, pair bounces and noise
// under several limit settings and handshake idling patterns, then repeat
// runs near the top limits; a separate checker predicts and compares the flag words
// ----------------------------------------------------------------------------
module guest_idle_loop_detector_tb;
    import gild_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SOAK_LEN    = 20;
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = {{REG_IDX_W{1'b1}}, 2'b00};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_word              in_word;
    logic                  out_valid;
    logic                  out_stall;
    t_out_word             out_word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int due_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit send_quiet;
    bit recv_quiet;
    int words_sent;

    guest_idle_loop_detector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    guest_idle_loop_detector_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("** guest_idle_loop_detector: FAILED **");
        $finish;
    end

    // flag side backpressure
    initial begin
        out_stall  = 1'b0;
        recv_quiet = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(49) == 0) recv_quiet = !recv_quiet;
            out_stall = !recv_quiet && ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_in_word mk(input logic [MODE_W-1:0] m, input logic [ARG_W-1:0] a,
                                    input logic [ARG_W-1:0] b);
        t_in_word w;
        w.mode       = m;
        w.first_arg  = a;
        w.second_arg = b;
        return w;
    endfunction

    function automatic logic [ARG_W-1:0] pick_id();
        case ($urandom_range(5))
            0:       return '1;
            1:       return '0;
            2:       return ARG_W'($urandom_range(1, 3));
            default: return ARG_W'($urandom);
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input t_in_word w);
        while (!send_quiet && $urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_word  = w;
        do @(posedge i_clk); while (in_stall);
        words_sent = words_sent + 1;
        @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (due_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [LIMIT_W-1:0] sema, input logic [LIMIT_W-1:0] rot,
                              input logic [LIMIT_W-1:0] bnc);
        logic [APB_DATA_W-1:0] d;
        wait_drained();
        d = $urandom;
        d[LIMIT_W-1:0] = sema;
        apb_access(1'b1, {REG_SEMA_LIMIT, 2'b00}, d);
        d = $urandom;
        d[LIMIT_W-1:0] = rot;
        apb_access(1'b1, {REG_ROTATE_LIMIT, 2'b00}, d);
        d = $urandom;
        d[LIMIT_W-1:0] = bnc;
        apb_access(1'b1, {REG_BOUNCE_LIMIT, 2'b00}, d);
        apb_access(1'b0, {REG_SEMA_LIMIT, 2'b00}, '0);
        apb_access(1'b0, {REG_ROTATE_LIMIT, 2'b00}, '0);
        apb_access(1'b0, {REG_BOUNCE_LIMIT, 2'b00}, '0);
    endtask

    task automatic run_traffic(input int n);
        int                target;
        int                len;
        logic [ARG_W-1:0]  x;
        logic [ARG_W-1:0]  y;
        logic [MODE_W-1:0] m;
        logic              sema_family;
        target = words_sent + n;
        while (words_sent < target) begin
            len        = $urandom_range(1, 25);
            x          = pick_id();
            y          = pick_id();
            send_quiet = ($urandom_range(5) == 0);
            case ($urandom_range(9))
                0, 1: begin
                    // semaphore repeats, rotations and unused modes mixed in
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(9) == 0) begin
                            m = MODE_W'($urandom_range(4, 7));
                            send_word(mk(m, pick_id(), pick_id()));
                        end else begin
                            m = $urandom_range(1) ? MODE_WAIT_SEMA : MODE_SIGNAL_SEMA;
                            send_word(mk(m, x, pick_id()));
                        end
                    end
                end
                2, 3: begin
                    for (int i = 0; i < len; i++) begin
                        case ($urandom_range(9))
                            0:       send_word(mk(MODE_CHANGE_THR, x, pick_id()));
                            1:       send_word(mk(MODE_OTHER, pick_id(), pick_id()));
                            default: send_word(mk(MODE_ROTATE, x, x));
                        endcase
                    end
                end
                4, 5: begin
                    if (y == x) y = ~x;
                    for (int i = 0; i < len; i++) begin
                        case ($urandom_range(9))
                            0:       send_word(mk(MODE_CHANGE_THR, $urandom_range(1) ? x : y, '0));
                            1:       send_word(mk(MODE_OTHER, pick_id(), pick_id()));
                            default: begin
                                if ($urandom_range(1)) send_word(mk(MODE_ROTATE, x, y));
                                else send_word(mk(MODE_ROTATE, y, x));
                            end
                        endcase
                    end
                end
                6: begin
                    // sequence broken halfway
                    sema_family = $urandom_range(1);
                    for (int i = 0; i < len; i++) begin
                        if (i == len / 2) begin
                            if ($urandom_range(3) == 0) begin
                                send_word(mk(MODE_INTERRUPT, pick_id(), pick_id()));
                            end else if (sema_family) x = pick_id();
                            else y = pick_id();
                        end
                        if (sema_family) send_word(mk(MODE_WAIT_SEMA, x, y));
                        else send_word(mk(MODE_ROTATE, $urandom_range(1) ? x : y, x));
                    end
                end
                default: begin
                    for (int i = 0; i < len / 3 + 1; i++) begin
                        m = MODE_W'($urandom_range(7));
                        send_word(mk(m, pick_id(), pick_id()));
                    end
                end
            endcase
        end
        send_quiet = 1'b0;
    endtask

    initial begin
        logic [ARG_W-1:0] ta;
        logic [ARG_W-1:0] tb;
        i_rst_n       = 1'b0;
        in_valid      = 1'b0;
        in_word       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 28;
        recv_idle_pct = 78;
        send_quiet    = 1'b0;
        words_sent    = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset limits read back, unmapped write ignored
        apb_access(1'b1, UNMAPPED_ADDR, $urandom);
        apb_access(1'b0, {REG_SEMA_LIMIT, 2'b00}, '0);
        apb_access(1'b0, {REG_ROTATE_LIMIT, 2'b00}, '0);
        apb_access(1'b0, {REG_BOUNCE_LIMIT, 2'b00}, '0);

        ta = 32'h1234_5678;
        tb = 32'h9abc_def0;
        send_word(mk(MODE_WAIT_SEMA, '1, '0));
        send_word(mk(MODE_SIGNAL_SEMA, '1, '1));
        send_word(mk(MODE_WAIT_SEMA, '0, '1));
        send_word(mk(MODE_SIGNAL_SEMA, '0, '0));
        send_word(mk(MODE_OTHER, '1, '1));
        send_word(mk(MODE_W'(6), ta, tb));
        send_word(mk(MODE_W'(7), tb, ta));
        send_word(mk(MODE_INTERRUPT, '1, '0));
        send_word(mk(MODE_ROTATE, '1, '1));
        send_word(mk(MODE_ROTATE, '1, '1));
        send_word(mk(MODE_CHANGE_THR, '1, '0));
        send_word(mk(MODE_CHANGE_THR, '0, '1));
        send_word(mk(MODE_ROTATE, ta, tb));
        send_word(mk(MODE_ROTATE, tb, ta));
        send_word(mk(MODE_ROTATE, ta, tb));
        send_word(mk(MODE_CHANGE_THR, ta, '0));
        send_word(mk(MODE_ROTATE, ta, ta));
        send_word(mk(MODE_CHANGE_THR, ta, '1));
        send_word(mk(MODE_INTERRUPT, ta, tb));
        send_word(mk(MODE_WAIT_SEMA, 32'h5555_5555, 32'haaaa_aaaa));
        send_word(mk(MODE_WAIT_SEMA, 32'h5555_5555, 32'h5555_5555));
        send_word(mk(MODE_ROTATE, 32'haaaa_aaaa, 32'h5555_5555));

        set_limits(16'd3, 16'd5, 16'd2);
        run_traffic(410);

        send_idle_pct = 78;
        recv_idle_pct = 28;
        set_limits('0, '0, '0);
        run_traffic(410);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(LIMIT_W'($urandom_range(1, 12)), LIMIT_W'($urandom_range(1, 12)),
                   LIMIT_W'($urandom_range(1, 12)));
        run_traffic(420);

        // repeat runs against the top limits
        set_limits('1, 16'hfffe, 16'hfffe);
        ta = pick_id();
        tb = pick_id();
        repeat (SOAK_LEN) send_word(mk(MODE_SIGNAL_SEMA, ta, tb));
        repeat (SOAK_LEN) send_word(mk(MODE_ROTATE, tb, tb));
        send_word(mk(MODE_CHANGE_THR, tb, ta));
        send_word(mk(MODE_ROTATE, tb, ~tb));
        send_word(mk(MODE_WAIT_SEMA, ~ta, tb));

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("** guest_idle_loop_detector: PASSED **");
        end else begin
            $display("** guest_idle_loop_detector: FAILED **");
        end
        $finish;
    end

endmodule
